// ----- rtl/sip_pkg.sv -----
// ----------------------------------------------------------------------------
// sip_pkg: shared types and constants for the segment intersection block
// Default widths, the epsilon register reset value, hit kind codes, queue
// status and the widths of the packed items that the queues carry.
// ----------------------------------------------------------------------------
package sip_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int EPS_WIDTH       = 16;
  localparam int EPS_RESET       = 1;
  localparam int QUEUE_DEPTH     = 2;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_B_START,
    KIND_B_END,
    KIND_A_START,
    KIND_A_END
  } hit_kind_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // classified item between front and back end
  function automatic int mid_width(input int w);
    return 10 * w + 14;
  endfunction

  // result item: hit, x, y, kind
  function automatic int res_width(input int w);
    return 2 * w + 4;
  endfunction

endpackage

// ----- rtl/segment_intersection_point.sv -----
// ----------------------------------------------------------------------------
// segment_intersection_point: 2D segment intersection in signed fixed point
// Results come from the back end, whose divider makes one quotient bit per stage.
// Throughput: one item per cycle; both sides stall independently.
// Reset: synchronous, clears queues and valids; epsilon returns to 1.
// ----------------------------------------------------------------------------
module segment_intersection_point #(
  parameter int COORD_WIDTH = sip_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = sip_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          epsilon_we,
  input  logic [sip_pkg::EPS_WIDTH-1:0] epsilon_wdata,
  input  logic                          push,
  output logic                          full,
  input  logic signed [COORD_WIDTH-1:0] a_start_x,
  input  logic signed [COORD_WIDTH-1:0] a_start_y,
  input  logic signed [COORD_WIDTH-1:0] a_end_x,
  input  logic signed [COORD_WIDTH-1:0] a_end_y,
  input  logic signed [COORD_WIDTH-1:0] b_start_x,
  input  logic signed [COORD_WIDTH-1:0] b_start_y,
  input  logic signed [COORD_WIDTH-1:0] b_end_x,
  input  logic signed [COORD_WIDTH-1:0] b_end_y,
  output logic                          empty,
  input  logic                          pop,
  output logic                          hit,
  output logic signed [COORD_WIDTH-1:0] cross_x,
  output logic signed [COORD_WIDTH-1:0] cross_y,
  output logic [2:0]                    hit_kind
);
  import sip_pkg::*;

  localparam int QW = mid_width(COORD_WIDTH);
  localparam int RW = res_width(COORD_WIDTH);

  // tolerance register
  logic [EPS_WIDTH-1:0] epsilon;
  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon <= EPS_WIDTH'(EPS_RESET);
    end else if (epsilon_we) begin
      epsilon <= epsilon_wdata;
    end
  end

  fifo_stat_t    mid_stat;
  fifo_stat_t    out_stat;
  logic          mid_push;
  logic          mid_pop;
  logic [QW-1:0] mid_wdata;
  logic [QW-1:0] mid_rdata;
  logic          out_push;
  logic [RW-1:0] out_wdata;
  logic [RW-1:0] out_rdata;

  assign full  = mid_stat.full;
  assign empty = out_stat.empty;

  // front end: tests and classification
  sip_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .eps       (epsilon),
    .in_valid  (push && !full),
    .a_start_x (a_start_x),
    .a_start_y (a_start_y),
    .a_end_x   (a_end_x),
    .a_end_y   (a_end_y),
    .b_start_x (b_start_x),
    .b_start_y (b_start_y),
    .b_end_x   (b_end_x),
    .b_end_y   (b_end_y),
    .q_stat    (mid_stat),
    .q_push    (mid_push),
    .q_wdata   (mid_wdata)
  );

  // queue between front and back
  sip_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .wdata (mid_wdata),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .stat  (mid_stat)
  );

  // back end: interpolation
  sip_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_rdata (mid_rdata),
    .q_stat  (mid_stat),
    .q_pop   (mid_pop),
    .o_stat  (out_stat),
    .o_push  (out_push),
    .o_wdata (out_wdata)
  );

  // result queue
  sip_fifo #(
    .WIDTH (RW),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_wdata),
    .pop   (pop),
    .rdata (out_rdata),
    .stat  (out_stat)
  );

  assign {hit, cross_x, cross_y, hit_kind} = out_rdata;

endmodule

// ----- rtl/sip_fifo.sv -----
// ----------------------------------------------------------------------------
// sip_fifo: small first-word-fall-through queue
// Register array with read and write pointers and an item count. The head
// item is shown while the queue is not empty.
// ----------------------------------------------------------------------------
module sip_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [WIDTH-1:0]    wdata,
  input  logic                pop,
  output logic [WIDTH-1:0]    rdata,
  output sip_pkg::fifo_stat_t stat
);
  import sip_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [NW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign stat.full  = (count == NW'(DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/sip_front.sv -----
// ----------------------------------------------------------------------------
// sip_front: point tests and classification
// Five-stage pipeline: capture, differences and box checks, products, cross
// products and squared lengths, tolerance compares; then endpoint priority
// and the straddle decision. Pushes one classified item per input item.
// ----------------------------------------------------------------------------
module sip_front #(
  parameter int COORD_WIDTH = sip_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = sip_pkg::FRAC_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic [sip_pkg::EPS_WIDTH-1:0]               eps,
  input  logic                                        in_valid,
  input  logic signed [COORD_WIDTH-1:0]               a_start_x,
  input  logic signed [COORD_WIDTH-1:0]               a_start_y,
  input  logic signed [COORD_WIDTH-1:0]               a_end_x,
  input  logic signed [COORD_WIDTH-1:0]               a_end_y,
  input  logic signed [COORD_WIDTH-1:0]               b_start_x,
  input  logic signed [COORD_WIDTH-1:0]               b_start_y,
  input  logic signed [COORD_WIDTH-1:0]               b_end_x,
  input  logic signed [COORD_WIDTH-1:0]               b_end_y,
  input  sip_pkg::fifo_stat_t                         q_stat,
  output logic                                        q_push,
  output logic [sip_pkg::mid_width(COORD_WIDTH)-1:0]  q_wdata
);
  import sip_pkg::*;

  localparam int W    = COORD_WIDTH;
  localparam int DW   = W + 1;
  localparam int PW   = 2 * DW;
  localparam int CW   = PW + 1;
  localparam int LW   = PW + 1;
  localparam int BW   = W + 2;
  localparam int TW   = EPS_WIDTH + FRAC_BITS;
  localparam int CMPW = (CW > TW + 1) ? CW : TW + 1;
  localparam int EW   = 2 * EPS_WIDTH;
  localparam int LCW  = (LW > EW) ? LW : EW;

  // coordinate slots: A start x/y, A end x/y, B start x/y, B end x/y
  function automatic int pidx(input int i);
    return (i == 0) ? 4 : (i == 1) ? 6 : (i == 2) ? 0 : 2;
  endfunction
  function automatic int sidx(input int i);
    return (i < 2) ? 0 : 4;
  endfunction
  function automatic int eidx(input int i);
    return (i < 2) ? 2 : 6;
  endfunction

  function automatic logic within_f(input logic signed [W-1:0] v,
                                    input logic signed [W-1:0] b1,
                                    input logic signed [W-1:0] b2,
                                    input logic [EPS_WIDTH-1:0] e);
    logic signed [BW-1:0] ve;
    logic signed [BW-1:0] b1e;
    logic signed [BW-1:0] b2e;
    logic signed [BW-1:0] ee;
    ve  = BW'(v);
    b1e = BW'(b1);
    b2e = BW'(b2);
    ee  = $signed(BW'(e));
    return ((ve >= b1e - ee) && (ve <= b2e + ee)) ||
           ((ve >= b2e - ee) && (ve <= b1e + ee));
  endfunction

  function automatic logic near_f(input logic signed [DW-1:0] u,
                                  input logic [EPS_WIDTH-1:0] e);
    logic signed [BW-1:0] ue;
    logic signed [BW-1:0] ee;
    ue = BW'(u);
    ee = $signed(BW'(e));
    return (ue <= ee) && (ue >= -ee);
  endfunction

  function automatic logic signed [PW-1:0] smul(input logic signed [DW-1:0] a,
                                                input logic signed [DW-1:0] b);
    return PW'(a) * PW'(b);
  endfunction

  logic en;
  assign en = !q_stat.full;

  // tolerances from the live register
  logic [TW-1:0] thr;
  logic [EW-1:0] eps2;
  assign thr  = TW'(eps) << FRAC_BITS;
  assign eps2 = EW'(eps) * EW'(eps);

  // stage 0: input capture
  logic                 f0_vld;
  logic signed [W-1:0]  c0 [8];

  // stage 1: differences, box checks
  logic                 f1_vld;
  logic signed [W-1:0]  c1 [8];
  logic signed [DW-1:0] ux1 [4];
  logic signed [DW-1:0] uy1 [4];
  logic signed [DW-1:0] vx1 [4];
  logic signed [DW-1:0] vy1 [4];
  logic                 bnd1 [4];
  logic signed [DW-1:0] da1 [4];

  // stage 2: products
  logic                 f2_vld;
  logic signed [W-1:0]  c2 [8];
  logic signed [PW-1:0] p1_2 [4];
  logic signed [PW-1:0] p2_2 [4];
  logic signed [PW-1:0] sq2 [4];
  logic                 near2 [4];
  logic                 bnd2 [4];
  logic signed [DW-1:0] da2 [2];

  // stage 3: cross products, squared lengths
  logic                 f3_vld;
  logic signed [W-1:0]  c3 [8];
  logic signed [CW-1:0] cr3 [4];
  logic [LW-1:0]        lena3;
  logic [LW-1:0]        lenb3;
  logic                 near3 [4];
  logic                 bnd3 [4];
  logic signed [DW-1:0] da3 [2];

  // stage 4: compares, magnitudes
  logic                 f4_vld;
  logic signed [W-1:0]  c4 [8];
  logic                 cw4 [4];
  logic                 neg4 [4];
  logic                 zero4 [4];
  logic                 near4 [4];
  logic                 bnd4 [4];
  logic                 sa4;
  logic                 sb4;
  logic [CW-1:0]        m3_4;
  logic [CW-1:0]        m4_4;
  logic [DW-1:0]        nx4;
  logic [DW-1:0]        ny4;
  logic                 dnx4;
  logic                 dny4;

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      f0_vld <= 1'b0;
      f1_vld <= 1'b0;
      f2_vld <= 1'b0;
      f3_vld <= 1'b0;
      f4_vld <= 1'b0;
    end else if (en) begin
      f0_vld <= in_valid;
      f1_vld <= f0_vld;
      f2_vld <= f1_vld;
      f3_vld <= f2_vld;
      f4_vld <= f3_vld;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (en) begin
      c0 <= '{a_start_x, a_start_y, a_end_x, a_end_y,
              b_start_x, b_start_y, b_end_x, b_end_y};
      c1 <= c0;
      c2 <= c1;
      c3 <= c2;
      c4 <= c3;

      for (int i = 0; i < 4; i++) begin
        // point p against segment (s, e): u = s - p, v = e - p
        ux1[i]  <= DW'(c0[sidx(i)])     - DW'(c0[pidx(i)]);
        uy1[i]  <= DW'(c0[sidx(i) + 1]) - DW'(c0[pidx(i) + 1]);
        vx1[i]  <= DW'(c0[eidx(i)])     - DW'(c0[pidx(i)]);
        vy1[i]  <= DW'(c0[eidx(i) + 1]) - DW'(c0[pidx(i) + 1]);
        bnd1[i] <= within_f(c0[pidx(i)], c0[sidx(i)], c0[eidx(i)], eps) &&
                   within_f(c0[pidx(i) + 1], c0[sidx(i) + 1], c0[eidx(i) + 1], eps);

        p1_2[i]  <= smul(ux1[i], vy1[i]);
        p2_2[i]  <= smul(uy1[i], vx1[i]);
        near2[i] <= near_f(ux1[i], eps) && near_f(uy1[i], eps);
        bnd2[i]  <= bnd1[i];
        sq2[i]   <= smul(da1[i], da1[i]);

        cr3[i]   <= CW'(p1_2[i]) - CW'(p2_2[i]);
        near3[i] <= near2[i];
        bnd3[i]  <= bnd2[i];

        cw4[i]   <= (CMPW'(cr3[i]) <= $signed(CMPW'(thr))) &&
                    (CMPW'(cr3[i]) >= -$signed(CMPW'(thr)));
        neg4[i]  <= cr3[i][CW-1];
        zero4[i] <= (cr3[i] == '0);
        near4[i] <= near3[i];
        bnd4[i]  <= bnd3[i];
      end

      // segment deltas: A x, A y, B x, B y
      da1[0] <= DW'(c0[2]) - DW'(c0[0]);
      da1[1] <= DW'(c0[3]) - DW'(c0[1]);
      da1[2] <= DW'(c0[6]) - DW'(c0[4]);
      da1[3] <= DW'(c0[7]) - DW'(c0[5]);
      da2[0] <= da1[0];
      da2[1] <= da1[1];

      lena3  <= $unsigned(LW'(sq2[0]) + LW'(sq2[1]));
      lenb3  <= $unsigned(LW'(sq2[2]) + LW'(sq2[3]));
      da3    <= da2;

      sa4  <= (LCW'(lena3) <= LCW'(eps2));
      sb4  <= (LCW'(lenb3) <= LCW'(eps2));
      m3_4 <= cr3[2][CW-1] ? CW'(-cr3[2]) : CW'(cr3[2]);
      m4_4 <= cr3[3][CW-1] ? CW'(-cr3[3]) : CW'(cr3[3]);
      // offset d = A start - A end = -delta
      nx4  <= da3[0][DW-1] ? DW'(-da3[0]) : DW'(da3[0]);
      ny4  <= da3[1][DW-1] ? DW'(-da3[1]) : DW'(da3[1]);
      dnx4 <= !da3[0][DW-1] && (da3[0] != '0);
      dny4 <= !da3[1][DW-1] && (da3[1] != '0);
    end
  end

  // classification
  logic                on [4];
  logic                s12;
  logic                s34;
  logic                interp;
  logic [2:0]          kind;
  logic signed [W-1:0] ptx;
  logic signed [W-1:0] pty;
  logic [CW-1:0]       den;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if ((i < 2) ? sa4 : sb4) begin
        on[i] = near4[i];
      end else begin
        on[i] = cw4[i] && bnd4[i];
      end
    end
    s12    = !zero4[0] && !zero4[1] && (neg4[0] != neg4[1]);
    s34    = !zero4[2] && !zero4[3] && (neg4[2] != neg4[3]);
    interp = 1'b0;
    priority if (on[0]) begin
      kind = KIND_B_START;
      ptx  = c4[4];
      pty  = c4[5];
    end else if (on[1]) begin
      kind = KIND_B_END;
      ptx  = c4[6];
      pty  = c4[7];
    end else if (on[2]) begin
      kind = KIND_A_START;
      ptx  = c4[0];
      pty  = c4[1];
    end else if (on[3]) begin
      kind = KIND_A_END;
      ptx  = c4[2];
      pty  = c4[3];
    end else if (!sa4 && !sb4 && s12 && s34) begin
      kind   = KIND_A_END;
      interp = 1'b1;
      ptx    = '0;
      pty    = '0;
    end else begin
      kind = KIND_NONE;
      ptx  = '0;
      pty  = '0;
    end
    den = m3_4 + m4_4;
  end

  assign q_push  = f4_vld && en;
  assign q_wdata = {kind, interp, ptx, pty, c4[2], c4[3], dnx4, dny4,
                    nx4, ny4, m4_4, den};

endmodule

// ----- rtl/sip_back.sv -----
// ----------------------------------------------------------------------------
// sip_back: crossing point interpolation
// Scales the A offset by |cc4| / (|cc4| + |cc3|): split partial products,
// their sum, then a restoring divider with one quotient bit per stage for
// both axes. Endpoint and no-hit items ride along unchanged.
// ----------------------------------------------------------------------------
module sip_back #(
  parameter int COORD_WIDTH = sip_pkg::COORD_WIDTH_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic [sip_pkg::mid_width(COORD_WIDTH)-1:0]  q_rdata,
  input  sip_pkg::fifo_stat_t                         q_stat,
  output logic                                        q_pop,
  input  sip_pkg::fifo_stat_t                         o_stat,
  output logic                                        o_push,
  output logic [sip_pkg::res_width(COORD_WIDTH)-1:0]  o_wdata
);
  import sip_pkg::*;

  localparam int W    = COORD_WIDTH;
  localparam int NW   = W + 1;
  localparam int MW   = 2 * W + 3;
  localparam int ML   = (MW + 1) / 2;
  localparam int MH   = MW - ML;
  localparam int PLW  = NW + ML;
  localparam int PHW  = NW + MH;
  localparam int NPW  = NW + MW;
  localparam int PLDW = 4 * W + 6;
  localparam int NS   = W + 1;
  localparam int XW   = W + 2;

  function automatic logic [MW:0] div_step(input logic [MW-1:0] r,
                                           input logic b,
                                           input logic [MW-1:0] d);
    logic [MW:0] t;
    logic [MW:0] dd;
    t  = {r, b};
    dd = {1'b0, d};
    if (t >= dd) begin
      return {1'b1, MW'(t - dd)};
    end
    return {1'b0, t[MW-1:0]};
  endfunction

  function automatic logic [W-1:0] offset_f(input logic signed [W-1:0] e,
                                            input logic neg,
                                            input logic [NW-1:0] q);
    logic signed [XW-1:0] ev;
    logic signed [XW-1:0] qv;
    logic signed [XW-1:0] r;
    ev = XW'(e);
    qv = $signed(XW'(q));
    r  = neg ? ev - qv : ev + qv;
    return r[W-1:0];
  endfunction

  logic en;
  assign en    = !o_stat.full;
  assign q_pop = en && !q_stat.empty;

  // queue item fields
  logic [PLDW-1:0] pld_in;
  logic [NW-1:0]   nx_in;
  logic [NW-1:0]   ny_in;
  logic [MW-1:0]   m4_in;
  logic [MW-1:0]   den_in;
  assign {pld_in, nx_in, ny_in, m4_in, den_in} = q_rdata;

  // stage B0: capture
  logic            b0_vld;
  logic [PLDW-1:0] pld0;
  logic [NW-1:0]   nx0;
  logic [NW-1:0]   ny0;
  logic [MW-1:0]   m4_0;
  logic [MW-1:0]   den0;

  // stage B1: partial products
  logic            b1_vld;
  logic [PLDW-1:0] pld1;
  logic [MW-1:0]   den1;
  logic [PLW-1:0]  plx1;
  logic [PHW-1:0]  phx1;
  logic [PLW-1:0]  ply1;
  logic [PHW-1:0]  phy1;

  // divider stages
  logic            vld  [NS+1];
  logic [PLDW-1:0] pld  [NS+1];
  logic [MW-1:0]   den  [NS+1];
  logic [MW-1:0]   remx [NS+1];
  logic [MW-1:0]   remy [NS+1];
  logic [NW-1:0]   lowx [NS+1];
  logic [NW-1:0]   lowy [NS+1];
  logic [NW-1:0]   qx   [NS+1];
  logic [NW-1:0]   qy   [NS+1];

  logic [NPW-1:0]  numx;
  logic [NPW-1:0]  numy;
  assign numx = NPW'(plx1) + (NPW'(phx1) << ML);
  assign numy = NPW'(ply1) + (NPW'(phy1) << ML);

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      b0_vld <= 1'b0;
      b1_vld <= 1'b0;
      for (int s = 0; s <= NS; s++) begin
        vld[s] <= 1'b0;
      end
    end else if (en) begin
      b0_vld <= q_pop;
      b1_vld <= b0_vld;
      vld[0] <= b1_vld;
      for (int s = 1; s <= NS; s++) begin
        vld[s] <= vld[s-1];
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    logic [MW:0] stx;
    logic [MW:0] sty;
    if (en) begin
      pld0 <= pld_in;
      nx0  <= nx_in;
      ny0  <= ny_in;
      m4_0 <= m4_in;
      den0 <= den_in;

      pld1 <= pld0;
      den1 <= den0;
      plx1 <= PLW'(nx0) * PLW'(m4_0[ML-1:0]);
      phx1 <= PHW'(nx0) * PHW'(m4_0[MW-1:ML]);
      ply1 <= PLW'(ny0) * PLW'(m4_0[ML-1:0]);
      phy1 <= PHW'(ny0) * PHW'(m4_0[MW-1:ML]);

      // top of the numerator is below the divisor
      pld[0]  <= pld1;
      den[0]  <= den1;
      remx[0] <= numx[NPW-1 -: MW];
      remy[0] <= numy[NPW-1 -: MW];
      lowx[0] <= numx[NW-1:0];
      lowy[0] <= numy[NW-1:0];
      qx[0]   <= '0;
      qy[0]   <= '0;

      for (int s = 1; s <= NS; s++) begin
        stx     = div_step(remx[s-1], lowx[s-1][NW-1], den[s-1]);
        sty     = div_step(remy[s-1], lowy[s-1][NW-1], den[s-1]);
        pld[s]  <= pld[s-1];
        den[s]  <= den[s-1];
        remx[s] <= stx[MW-1:0];
        remy[s] <= sty[MW-1:0];
        lowx[s] <= lowx[s-1] << 1;
        lowy[s] <= lowy[s-1] << 1;
        qx[s]   <= {qx[s-1][NW-2:0], stx[MW]};
        qy[s]   <= {qy[s-1][NW-2:0], sty[MW]};
      end
    end
  end

  // result assembly
  logic [2:0]          kind;
  logic                interp;
  logic signed [W-1:0] ptx;
  logic signed [W-1:0] pty;
  logic signed [W-1:0] ex;
  logic signed [W-1:0] ey;
  logic                dnx;
  logic                dny;
  logic [W-1:0]        rx;
  logic [W-1:0]        ry;

  assign {kind, interp, ptx, pty, ex, ey, dnx, dny} = pld[NS];
  assign rx      = interp ? offset_f(ex, dnx, qx[NS]) : ptx;
  assign ry      = interp ? offset_f(ey, dny, qy[NS]) : pty;
  assign o_push  = vld[NS] && en;
  assign o_wdata = {kind != KIND_NONE, rx, ry, kind};

endmodule
